// ----- hdl/fmp_pkg.sv -----
// ----------------------------------------------------------------------------
// fmp_pkg
// Shared types and constants of the framed message parser.
// ----------------------------------------------------------------------------
package fmp_pkg;

   localparam logic [7:0]  MAGIC_FIRST   = 8'hCA;
   localparam logic [7:0]  MAGIC_SECOND  = 8'hFE;
   localparam logic [15:0] MAX_LEN_RESET = 16'd4096;
   localparam logic [7:0]  TYPE_LOW      = 8'h01;
   localparam logic [7:0]  TYPE_HIGH     = 8'h03;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_MAGIC    = 3'd1,
      ST_TOO_LONG     = 3'd2,
      ST_BAD_TYPE     = 3'd3,
      ST_TRUNCATED    = 3'd4,
      ST_BAD_CHECKSUM = 3'd5
   } status_type;

   // one result item, is_verdict in the lowest bit
   typedef struct packed {
      logic [15:0] frame_length;
      status_type  status;
      logic [1:0]  message_type;
      logic [7:0]  payload_byte;
      logic        is_verdict;
   } result_type;

   // front to queue push
   typedef struct packed {
      logic       valid;
      result_type data;
   } push_type;

endpackage

// ----- hdl/fmp_parser.sv -----
// ----------------------------------------------------------------------------
// fmp_parser
// Front end: takes buffer bytes, walks the frame header and payload, and
// classifies each byte into a tentative payload byte, a verdict or nothing.
// ----------------------------------------------------------------------------
module fmp_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              end_of_buffer,
   output fmp_pkg::push_type push
);

   typedef enum logic [2:0] {
      PH_MAGIC0  = 3'd0,
      PH_MAGIC1  = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_TYPE    = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_CHECK   = 3'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  xor_ff, xor_in;
   logic [1:0]  type_ff, type_in;
   logic        done_ff, done_in;
   logic [15:0] max_len_ff;

   logic                 verdict;
   logic                 emit;
   logic                 has_len;
   logic [15:0]          full_len;
   logic [15:0]          left_dec;
   fmp_pkg::status_type  status;
   fmp_pkg::result_type  res;

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      left_in   = left_ff;
      xor_in    = xor_ff;
      type_in   = type_ff;
      done_in   = done_ff;
      verdict   = 1'b0;
      emit      = 1'b0;
      status    = fmp_pkg::ST_OK;
      has_len   = (phase_ff == PH_TYPE) || (phase_ff == PH_PAYLOAD) ||
                  (phase_ff == PH_CHECK);
      full_len  = {data_byte, length_ff[7:0]};
      left_dec  = left_ff - 16'd1;
      res       = '0;

      if (!done_ff) begin
         case (phase_ff)
            PH_MAGIC0: begin
               if (data_byte != fmp_pkg::MAGIC_FIRST) begin
                  verdict = 1'b1;
                  status  = fmp_pkg::ST_BAD_MAGIC;
               end else begin
                  phase_in = PH_MAGIC1;
               end
            end
            PH_MAGIC1: begin
               if (data_byte != fmp_pkg::MAGIC_SECOND) begin
                  verdict = 1'b1;
                  status  = fmp_pkg::ST_BAD_MAGIC;
               end else begin
                  phase_in = PH_LEN_LO;
               end
            end
            PH_LEN_LO: begin
               length_in = {8'd0, data_byte};
               phase_in  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               length_in = full_len;
               has_len   = 1'b1;
               if (full_len > max_len_ff) begin
                  verdict = 1'b1;
                  status  = fmp_pkg::ST_TOO_LONG;
               end else begin
                  left_in  = full_len;
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               if (data_byte < fmp_pkg::TYPE_LOW || data_byte > fmp_pkg::TYPE_HIGH) begin
                  verdict = 1'b1;
                  status  = fmp_pkg::ST_BAD_TYPE;
               end else begin
                  type_in  = data_byte[1:0];
                  phase_in = (left_ff != 16'd0) ? PH_PAYLOAD : PH_CHECK;
               end
            end
            PH_PAYLOAD: begin
               if (!end_of_buffer) begin
                  xor_in  = xor_ff ^ data_byte;
                  left_in = left_dec;
                  if (left_dec == 16'd0) begin
                     phase_in = PH_CHECK;
                  end
                  emit             = 1'b1;
                  res.payload_byte = data_byte;
               end
            end
            PH_CHECK: begin
               verdict = 1'b1;
               status  = (xor_ff == data_byte) ? fmp_pkg::ST_OK
                                               : fmp_pkg::ST_BAD_CHECKSUM;
            end
            default: begin
               phase_in = PH_MAGIC0;
            end
         endcase

         // buffer ran out before the checksum byte
         if (!verdict && end_of_buffer) begin
            verdict = 1'b1;
            status  = fmp_pkg::ST_TRUNCATED;
         end

         if (verdict) begin
            emit             = 1'b1;
            done_in          = 1'b1;
            res.is_verdict   = 1'b1;
            res.status       = status;
            res.message_type = (status == fmp_pkg::ST_BAD_TYPE) ? 2'd0 : type_in;
            res.frame_length = has_len ? length_in : 16'd0;
         end
      end

      if (end_of_buffer) begin
         phase_in  = PH_MAGIC0;
         length_in = '0;
         left_in   = '0;
         xor_in    = '0;
         type_in   = '0;
         done_in   = 1'b0;
      end
   end

   assign push.valid = accept && emit;
   assign push.data  = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC0;
         length_ff  <= '0;
         left_ff    <= '0;
         xor_ff     <= '0;
         type_ff    <= '0;
         done_ff    <= 1'b0;
         max_len_ff <= fmp_pkg::MAX_LEN_RESET;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff  <= phase_in;
            length_ff <= length_in;
            left_ff   <= left_in;
            xor_ff    <= xor_in;
            type_ff   <= type_in;
            done_ff   <= done_in;
         end
      end
   end

endmodule

// ----- hdl/fmp_queue.sv -----
// ----------------------------------------------------------------------------
// fmp_queue
// Back end: two-entry result queue that drives the result channel from
// registers and decouples it from the parser.
// ----------------------------------------------------------------------------
module fmp_queue (
   input  logic                clock,
   input  logic                reset,
   input  fmp_pkg::push_type   push,
   output logic                has_room,
   output logic                out_valid,
   input  logic                out_ready,
   output fmp_pkg::result_type out_data
);

   fmp_pkg::result_type mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign has_room  = (count_ff != 2'd2);
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push.valid) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

endmodule

// ----- hdl/framed_message_parser.sv -----
// ----------------------------------------------------------------------------
// framed_message_parser
// Parses magic / length / type / payload / XOR-checksum frames from a byte
// stream and emits tentative payload bytes and one verdict per buffer.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one buffer byte per transaction, req_tlast on the buffer's
//   last byte. rsp_* carries results: tentative payload bytes (rsp_tuser 0)
//   and one verdict per buffer (rsp_tuser 1: status, type, frame length).
//   A byte that yields a result writes it into the two-entry result queue,
//   whose registers drive rsp_*; header bytes and bytes after a verdict
//   produce no result. Throughput is one byte per cycle while the queue
//   has room, set by the parser's per-byte update and the result queue.
//   csr_wr_en/csr_wr_data write the maximum payload length (reset 4096);
//   write only while idle.
//   Reset (synchronous) returns the parser to the first magic byte and
//   empties the queue. If the receiver stalls, the queue fills after two
//   results and req_tready drops until an entry drains.
// ----------------------------------------------------------------------------
module framed_message_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   input  logic        req_tlast,  // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [7:0] payload_byte, [9:8] message_type,
                                   // [12:10] status, [28:13] frame_length,
                                   // [31:29] zero
   output logic        rsp_tuser   // is_verdict
);

   fmp_pkg::push_type   push;
   fmp_pkg::result_type out_data;
   logic                has_room;
   logic                accept;

   assign req_tready = has_room;
   assign accept     = req_tvalid && has_room;

   fmp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .accept        (accept),
      .data_byte     (req_tdata),
      .end_of_buffer (req_tlast),
      .push          (push)
   );

   fmp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tuser = out_data.is_verdict;
   assign rsp_tdata = {3'b000, out_data.frame_length, out_data.status,
                       out_data.message_type, out_data.payload_byte};

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for framed_message_parser. A queue-fed stream driver
// sends whole buffers (directed corner frames, then random well-formed,
// truncated, corrupted and noise buffers) under several max-length settings.
// An in-bench parser predicts tentative payload bytes and verdicts, and a
// monitor checks every response transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } req_item_type;

   typedef enum logic [2:0] {
      WAIT_MAGIC0, WAIT_MAGIC1, LEN_LOW, LEN_HIGH, TYPE_BYTE, PAYLOAD, CHECKSUM
   } parse_phase_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   framed_message_parser u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   req_item_type         bytes_to_send[$];
   fmp_pkg::result_type  results_due[$];
   logic [7:0]           frame_bytes[$];

   // parser mirror
   parse_phase_type p_phase;
   logic [15:0]     p_max;
   logic [15:0]     p_len;
   logic [15:0]     p_left;
   logic [7:0]      p_xor;
   logic [1:0]      p_type;
   logic            p_done;

   logic [15:0] max_len_now = fmp_pkg::MAX_LEN_RESET;
   logic        req_fire = 1'b0;
   logic        sender_gaps = 1'b1;
   int unsigned stall_pct = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_done = 0;
   int unsigned hold_cycles = 0;
   int unsigned fail_count = 0;
   int unsigned byte_count = 0;
   int unsigned buffer_count = 0;
   int unsigned payload_count = 0;
   int unsigned verdict_count = 0;
   int unsigned status_hits[6];

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
   end

   task automatic clear_parse();
      p_phase = WAIT_MAGIC0;
      p_len   = '0;
      p_left  = '0;
      p_xor   = '0;
      p_type  = '0;
      p_done  = 1'b0;
   endtask

   // one accepted byte in, zero or one response out
   task automatic parse_byte(input logic [7:0] b, input logic eob);
      fmp_pkg::result_type r;
      fmp_pkg::status_type st;
      logic                flag;
      logic                has_len;
      r       = '0;
      st      = fmp_pkg::ST_OK;
      flag    = 1'b0;
      has_len = (p_phase >= TYPE_BYTE);
      if (p_done) begin
         if (eob) clear_parse();
         return;
      end
      case (p_phase)
         WAIT_MAGIC0: begin
            if (b != fmp_pkg::MAGIC_FIRST) begin
               flag = 1'b1;
               st   = fmp_pkg::ST_BAD_MAGIC;
            end else p_phase = WAIT_MAGIC1;
         end
         WAIT_MAGIC1: begin
            if (b != fmp_pkg::MAGIC_SECOND) begin
               flag = 1'b1;
               st   = fmp_pkg::ST_BAD_MAGIC;
            end else p_phase = LEN_LOW;
         end
         LEN_LOW: begin
            p_len   = {8'h00, b};
            p_phase = LEN_HIGH;
         end
         LEN_HIGH: begin
            p_len   = {b, p_len[7:0]};
            has_len = 1'b1;
            if (p_len > p_max) begin
               flag = 1'b1;
               st   = fmp_pkg::ST_TOO_LONG;
            end else begin
               p_left  = p_len;
               p_phase = TYPE_BYTE;
            end
         end
         TYPE_BYTE: begin
            if (b < fmp_pkg::TYPE_LOW || b > fmp_pkg::TYPE_HIGH) begin
               flag = 1'b1;
               st   = fmp_pkg::ST_BAD_TYPE;
            end else begin
               p_type  = b[1:0];
               p_phase = (p_left != 16'd0) ? PAYLOAD : CHECKSUM;
            end
         end
         PAYLOAD: begin
            if (!eob) begin
               p_xor  = p_xor ^ b;
               p_left = p_left - 16'd1;
               if (p_left == 16'd0) p_phase = CHECKSUM;
               r.payload_byte = b;
               results_due.push_back(r);
               return;
            end
         end
         default: begin
            flag = 1'b1;
            st   = (p_xor == b) ? fmp_pkg::ST_OK : fmp_pkg::ST_BAD_CHECKSUM;
         end
      endcase
      if (!flag && eob) begin
         flag = 1'b1;
         st   = fmp_pkg::ST_TRUNCATED;
      end
      if (flag) begin
         r.is_verdict   = 1'b1;
         r.status       = st;
         r.message_type = (st == fmp_pkg::ST_BAD_TYPE) ? 2'd0 : p_type;
         r.frame_length = has_len ? p_len : 16'd0;
         results_due.push_back(r);
         p_done = 1'b1;
      end
      if (eob) clear_parse();
   endtask

   // input acceptance, config tracking and response checking
   always @(posedge clock) begin : result_check
      fmp_pkg::result_type got;
      fmp_pkg::result_type want;
      if (reset) begin
         p_max    = fmp_pkg::MAX_LEN_RESET;
         req_fire = 1'b0;
         clear_parse();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.is_verdict   = rsp_tuser;
            got.payload_byte = rsp_tdata[7:0];
            got.message_type = rsp_tdata[9:8];
            got.status       = fmp_pkg::status_type'(rsp_tdata[12:10]);
            got.frame_length = rsp_tdata[28:13];
            if (results_due.size() == 0) begin
               $error("unexpected response transaction: tuser %b tdata %h",
                      rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = results_due.pop_front();
               if (got.is_verdict !== want.is_verdict) begin
                  $error("is_verdict: expected %0d, got %0d",
                         want.is_verdict, got.is_verdict);
                  fail_count++;
               end
               if (got.payload_byte !== want.payload_byte) begin
                  $error("payload_byte: expected %0d, got %0d",
                         want.payload_byte, got.payload_byte);
                  fail_count++;
               end
               if (got.message_type !== want.message_type) begin
                  $error("message_type: expected %0d, got %0d",
                         want.message_type, got.message_type);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.frame_length !== want.frame_length) begin
                  $error("frame_length: expected %0d, got %0d",
                         want.frame_length, got.frame_length);
                  fail_count++;
               end
               if (want.is_verdict) begin
                  verdict_count++;
                  status_hits[want.status]++;
               end else payload_count++;
            end
         end
         req_fire = req_tvalid && req_tready;
         if (req_fire) parse_byte(req_tdata, req_tlast);
         if (csr_wr_en) p_max = csr_wr_data;
      end
   end

   // sender: bursts of random length, random gaps between them unless sender_gaps is off
   always @(negedge clock) begin : driver
      req_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (bytes_to_send.size() != 0) begin
            it = bytes_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= it.data;
            req_tlast  <= it.last;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = sender_gaps ? $urandom_range(1, 6) : 0;
            end else burst_left--;
         end else req_tvalid <= 1'b0;
      end
   end

   // receiver: random stalls, plus long hold-offs on request
   always @(negedge clock) begin : receiver
      if (reset) rsp_tready <= 1'b0;
      else if (hold_cycles != 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done++;
         hold_cycles = 299;
         rsp_tready <= 1'b0;
      end else rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic send_buffer();
      req_item_type it;
      for (int i = 0; i < frame_bytes.size(); i++) begin
         it.data = frame_bytes[i];
         it.last = (i == frame_bytes.size() - 1);
         bytes_to_send.push_back(it);
      end
      byte_count += frame_bytes.size();
      buffer_count++;
   endtask

   // header, then payload and checksum; lengths over 64 are cut short, with no checksum, so they end truncated
   task automatic make_frame(input logic [15:0] len, input logic [7:0] typ,
                             input logic sum_ok);
      logic [7:0]  x;
      logic [7:0]  b;
      int unsigned n;
      frame_bytes.delete();
      frame_bytes.push_back(fmp_pkg::MAGIC_FIRST);
      frame_bytes.push_back(fmp_pkg::MAGIC_SECOND);
      frame_bytes.push_back(len[7:0]);
      frame_bytes.push_back(len[15:8]);
      frame_bytes.push_back(typ);
      n = (len > 64) ? $urandom_range(0, 8) : len;
      x = '0;
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom);
         x = x ^ b;
         frame_bytes.push_back(b);
      end
      if (n == len) frame_bytes.push_back(sum_ok ? x : x ^ 8'($urandom_range(1, 255)));
   endtask

   task automatic queue_random_buffer();
      int unsigned pick;
      int unsigned r;
      int unsigned cut;
      int unsigned idx;
      logic [15:0] len;
      logic [7:0]  typ;
      pick = $urandom_range(0, 99);
      r    = $urandom_range(0, 9);
      if (r < 6) len = 16'($urandom_range(0, 12));
      else if (r < 8) len = (max_len_now == 16'hFFFF) ? max_len_now
                            : 16'(max_len_now + $urandom_range(0, 1));
      else len = 16'($urandom_range(0, 65535));
      typ = 8'($urandom_range(1, 3));
      if (pick >= 80 && pick < 85) begin
         if (max_len_now != 16'hFFFF) len = 16'($urandom_range(max_len_now + 1, 65535));
         else len = 16'hFFFF;
      end else if (pick >= 85 && pick < 90) begin
         typ = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(4, 255));
      end
      make_frame(len, typ, $urandom_range(0, 6) != 0);
      if (pick < 55) begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
      end else if (pick < 70) begin
         cut = $urandom_range(1, frame_bytes.size() - 1);
         while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end else if (pick < 80) begin
         idx = $urandom_range(0, frame_bytes.size() - 1);
         frame_bytes[idx] = 8'($urandom);
      end else if (pick >= 90) begin
         frame_bytes.delete();
         repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
         if ($urandom_range(0, 1)) frame_bytes[0] = fmp_pkg::MAGIC_FIRST;
      end
      send_buffer();
   endtask

   task automatic write_max_len(input logic [15:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      max_len_now = value;
   endtask

   task automatic wait_drained();
      while (bytes_to_send.size() != 0 || req_tvalid || results_due.size() != 0)
         @(posedge clock);
      // header bytes give no response; let the pipe settle
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [15:0] limits[5];
      int unsigned target;
      limits[0] = fmp_pkg::MAX_LEN_RESET;
      limits[1] = 16'd0;
      limits[2] = 16'hFFFF;
      limits[3] = 16'($urandom_range(1, 16));
      limits[4] = 16'($urandom_range(17, 4000));
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 5; ph++) begin
         @(posedge clock);
         if (ph != 0) write_max_len(limits[ph]);
         sender_gaps = (ph != 1);
         stall_pct   = (ph == 1) ? 0 : $urandom_range(5, 60);
         if (ph == 0) begin
            frame_bytes = {8'hFF};
            send_buffer();
            frame_bytes = {fmp_pkg::MAGIC_FIRST, 8'h00};
            send_buffer();
            // ok frame with one trailing byte that must be ignored
            frame_bytes = {fmp_pkg::MAGIC_FIRST, fmp_pkg::MAGIC_SECOND, 8'h01, 8'h00,
                           8'h02, 8'h80, 8'h80, 8'h55};
            send_buffer();
            // bad type on the buffer's last byte wins over truncation
            frame_bytes = {fmp_pkg::MAGIC_FIRST, fmp_pkg::MAGIC_SECOND, 8'h01, 8'h00,
                           8'h04};
            send_buffer();
            // empty payload, nonzero checksum
            frame_bytes = {fmp_pkg::MAGIC_FIRST, fmp_pkg::MAGIC_SECOND, 8'h00, 8'h00,
                           8'h03, 8'h07};
            send_buffer();
            // one past the reset limit
            frame_bytes = {fmp_pkg::MAGIC_FIRST, fmp_pkg::MAGIC_SECOND, 8'h01, 8'h10};
            send_buffer();
            // buffer ends on a payload byte
            frame_bytes = {fmp_pkg::MAGIC_FIRST, fmp_pkg::MAGIC_SECOND, 8'h02, 8'h00,
                           8'h01, 8'h11};
            send_buffer();
         end
         target = byte_count + 385;
         while (byte_count < target) queue_random_buffer();
         if (ph == 0) begin
            repeat (20) @(posedge clock);
            hold_requests++;
         end
         wait_drained();
      end
      for (int k = 0; k < 1000 && results_due.size() != 0; k++) @(posedge clock);
      if (results_due.size() != 0) begin
         $error("%0d responses never arrived", results_due.size());
         fail_count++;
      end
      $display("Sent %0d bytes in %0d buffers under five max-length limits (reset, 0, %s",
               byte_count, buffer_count, "65535 and two random ones).");
      $display("Checked %0d payload bytes, %0d verdicts: ok %0d, magic %0d, long %0d, %s",
               payload_count, verdict_count, status_hits[fmp_pkg::ST_OK],
               status_hits[fmp_pkg::ST_BAD_MAGIC], status_hits[fmp_pkg::ST_TOO_LONG],
               $sformatf("type %0d, trunc %0d, sum %0d",
                         status_hits[fmp_pkg::ST_BAD_TYPE],
                         status_hits[fmp_pkg::ST_TRUNCATED],
                         status_hits[fmp_pkg::ST_BAD_CHECKSUM]));
      if (fail_count == 0) begin
         $display("** framed_message_parser: PASSED **");
      end else begin
         $display("** framed_message_parser: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #8000000;
      $display("** framed_message_parser: FAILED **");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/fmp_pkg.sv
hdl/fmp_parser.sv
hdl/fmp_queue.sv
hdl/framed_message_parser.sv
sim/tb_top.sv
